[src/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master line engine: channel words,
// engine state, phase codes, command codes and bus timing.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command codes carried in the operation field
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_WAIT_ACK = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  // Configuration reset values
  localparam logic [7:0] TICKS_PER_US_RST = 8'd16;
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

  // Bus timing in microseconds
  localparam logic [7:0] START_STOP_US = 8'd4;
  localparam logic [7:0] HALF_BIT_US   = 8'd2;
  localparam logic [7:0] STEP_US       = 8'd1;

  // Number of data bits in one byte transfer
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [15:0] {
    PH_IDLE   = 16'h0001,
    PH_ST_A   = 16'h0002,
    PH_ST_B   = 16'h0004,
    PH_SP_A   = 16'h0008,
    PH_SP_B   = 16'h0010,
    PH_SP_C   = 16'h0020,
    PH_W_LOW  = 16'h0040,
    PH_W_HIGH = 16'h0080,
    PH_W_TAIL = 16'h0100,
    PH_A_REL  = 16'h0200,
    PH_A_RISE = 16'h0400,
    PH_A_POLL = 16'h0800,
    PH_R_LOW  = 16'h1000,
    PH_R_HIGH = 16'h2000,
    PH_K_LOW  = 16'h4000,
    PH_K_HIGH = 16'h8000
  } phase_t;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] pending_op;
    logic [3:0] bit_count;
    logic [7:0] prescale_count;
    logic [7:0] microsecond_count;
    logic [7:0] shift_byte;
    logic       ack_choice;
    logic       scl;
    logic       sda;
    logic       sda_drive;
    logic [7:0] rx;
    logic       ack_fail;
  } state_t;

endpackage

[src/i2cm_step.sv]
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one tick of the I2C master line engine.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::state_t    st_i,
  input  i2cm_pkg::in_word_t  word_i,
  input  logic [7:0]          ticks_per_us_i,
  input  logic [7:0]          ack_timeout_i,
  output i2cm_pkg::state_t    st_o,
  output i2cm_pkg::out_word_t res_o
);

  logic [7:0] tpu;
  logic [7:0] pc_inc;
  logic [7:0] mc_inc;
  logic [3:0] bc_inc;
  logic [7:0] wait_n;
  logic       timed;
  logic       tick;
  logic       expire;
  logic       done;
  i2cm_pkg::state_t nx;

  assign tpu    = (ticks_per_us_i == 8'd0) ? 8'd1 : ticks_per_us_i;
  assign pc_inc = st_i.prescale_count + 8'd1;
  assign mc_inc = st_i.microsecond_count + 8'd1;
  assign bc_inc = st_i.bit_count + 4'd1;
  assign tick   = (pc_inc >= tpu);
  assign expire = tick && (mc_inc >= wait_n);

  // Delay length of each timed phase
  always_comb begin
    timed  = 1'b1;
    wait_n = i2cm_pkg::HALF_BIT_US;
    case (st_i.phase)
      i2cm_pkg::PH_ST_A, i2cm_pkg::PH_ST_B,
      i2cm_pkg::PH_SP_A, i2cm_pkg::PH_SP_C: begin
        wait_n = i2cm_pkg::START_STOP_US;
      end
      i2cm_pkg::PH_SP_B, i2cm_pkg::PH_A_REL,
      i2cm_pkg::PH_A_RISE, i2cm_pkg::PH_R_HIGH: begin
        wait_n = i2cm_pkg::STEP_US;
      end
      i2cm_pkg::PH_W_LOW, i2cm_pkg::PH_W_HIGH, i2cm_pkg::PH_W_TAIL,
      i2cm_pkg::PH_R_LOW, i2cm_pkg::PH_K_LOW, i2cm_pkg::PH_K_HIGH: begin
        wait_n = i2cm_pkg::HALF_BIT_US;
      end
      default: begin
        timed = 1'b0;
      end
    endcase
  end

  always_comb begin
    nx   = st_i;
    done = 1'b0;

    // Advance the microsecond timer in every timed phase
    if (timed) begin
      nx.prescale_count    = tick ? 8'd0 : pc_inc;
      nx.microsecond_count = tick ? (expire ? 8'd0 : mc_inc) : st_i.microsecond_count;
    end

    case (st_i.phase)
      i2cm_pkg::PH_IDLE: begin
        if (word_i.command_valid && (word_i.operation <= i2cm_pkg::OP_READ)) begin
          nx.pending_op        = word_i.operation;
          nx.prescale_count    = 8'd0;
          nx.microsecond_count = 8'd0;
          nx.bit_count         = 4'd0;
          case (word_i.operation)
            i2cm_pkg::OP_START: begin
              nx.sda_drive = 1'b1;
              nx.sda       = 1'b1;
              nx.scl       = 1'b1;
              nx.phase     = i2cm_pkg::PH_ST_A;
            end
            i2cm_pkg::OP_STOP: begin
              nx.sda_drive = 1'b1;
              nx.scl       = 1'b0;
              nx.sda       = 1'b0;
              nx.phase     = i2cm_pkg::PH_SP_A;
            end
            i2cm_pkg::OP_WRITE: begin
              nx.sda_drive  = 1'b1;
              nx.scl        = 1'b0;
              nx.sda        = word_i.tx_byte[7];
              nx.shift_byte = {word_i.tx_byte[6:0], 1'b0};
              nx.phase      = i2cm_pkg::PH_W_LOW;
            end
            i2cm_pkg::OP_WAIT_ACK: begin
              nx.sda_drive = 1'b0;
              nx.sda       = 1'b1;
              nx.phase     = i2cm_pkg::PH_A_REL;
            end
            default: begin
              nx.sda_drive  = 1'b0;
              nx.sda        = 1'b1;
              nx.scl        = 1'b0;
              nx.shift_byte = 8'd0;
              nx.ack_choice = word_i.send_ack;
              nx.phase      = i2cm_pkg::PH_R_LOW;
            end
          endcase
        end
      end
      i2cm_pkg::PH_ST_A: begin
        if (expire) begin
          nx.sda   = 1'b0;
          nx.phase = i2cm_pkg::PH_ST_B;
        end
      end
      i2cm_pkg::PH_ST_B: begin
        if (expire) begin
          nx.scl   = 1'b0;
          nx.phase = i2cm_pkg::PH_IDLE;
          done     = 1'b1;
        end
      end
      i2cm_pkg::PH_SP_A: begin
        if (expire) begin
          nx.scl   = 1'b1;
          nx.phase = i2cm_pkg::PH_SP_B;
        end
      end
      i2cm_pkg::PH_SP_B: begin
        if (expire) begin
          nx.sda   = 1'b1;
          nx.phase = i2cm_pkg::PH_SP_C;
        end
      end
      i2cm_pkg::PH_SP_C: begin
        if (expire) begin
          nx.phase = i2cm_pkg::PH_IDLE;
          done     = 1'b1;
        end
      end
      i2cm_pkg::PH_W_LOW: begin
        if (expire) begin
          nx.scl   = 1'b1;
          nx.phase = i2cm_pkg::PH_W_HIGH;
        end
      end
      i2cm_pkg::PH_W_HIGH: begin
        if (expire) begin
          nx.scl   = 1'b0;
          nx.phase = i2cm_pkg::PH_W_TAIL;
        end
      end
      i2cm_pkg::PH_W_TAIL: begin
        if (expire) begin
          nx.bit_count = bc_inc;
          if (bc_inc >= i2cm_pkg::BYTE_BITS) begin
            nx.phase = i2cm_pkg::PH_IDLE;
            done     = 1'b1;
          end else begin
            nx.sda        = st_i.shift_byte[7];
            nx.shift_byte = {st_i.shift_byte[6:0], 1'b0};
            nx.phase      = i2cm_pkg::PH_W_LOW;
          end
        end
      end
      i2cm_pkg::PH_A_REL: begin
        if (expire) begin
          nx.scl   = 1'b1;
          nx.phase = i2cm_pkg::PH_A_RISE;
        end
      end
      i2cm_pkg::PH_A_RISE: begin
        if (expire) begin
          nx.phase = i2cm_pkg::PH_A_POLL;
        end
      end
      i2cm_pkg::PH_A_POLL: begin
        if (!word_i.sda_in) begin
          nx.scl               = 1'b0;
          nx.ack_fail          = 1'b0;
          nx.prescale_count    = 8'd0;
          nx.microsecond_count = 8'd0;
          nx.phase             = i2cm_pkg::PH_IDLE;
          done                 = 1'b1;
        end else begin
          nx.prescale_count = tick ? 8'd0 : pc_inc;
          if (tick) begin
            if (st_i.microsecond_count >= ack_timeout_i) begin
              // Timed out: flag and fall into the stop sequence
              nx.ack_fail          = 1'b1;
              nx.sda_drive         = 1'b1;
              nx.scl               = 1'b0;
              nx.sda               = 1'b0;
              nx.prescale_count    = 8'd0;
              nx.microsecond_count = 8'd0;
              nx.phase             = i2cm_pkg::PH_SP_A;
            end else begin
              nx.microsecond_count = mc_inc;
            end
          end
        end
      end
      i2cm_pkg::PH_R_LOW: begin
        if (expire) begin
          nx.scl        = 1'b1;
          nx.shift_byte = {st_i.shift_byte[6:0], word_i.sda_in};
          nx.phase      = i2cm_pkg::PH_R_HIGH;
        end
      end
      i2cm_pkg::PH_R_HIGH: begin
        if (expire) begin
          nx.scl       = 1'b0;
          nx.bit_count = bc_inc;
          if (bc_inc >= i2cm_pkg::BYTE_BITS) begin
            nx.rx        = st_i.shift_byte;
            nx.sda_drive = 1'b1;
            nx.sda       = ~st_i.ack_choice;
            nx.phase     = i2cm_pkg::PH_K_LOW;
          end else begin
            nx.phase = i2cm_pkg::PH_R_LOW;
          end
        end
      end
      i2cm_pkg::PH_K_LOW: begin
        if (expire) begin
          nx.scl   = 1'b1;
          nx.phase = i2cm_pkg::PH_K_HIGH;
        end
      end
      i2cm_pkg::PH_K_HIGH: begin
        if (expire) begin
          nx.scl   = 1'b0;
          nx.phase = i2cm_pkg::PH_IDLE;
          done     = 1'b1;
        end
      end
      default: begin
        nx.phase = i2cm_pkg::PH_IDLE;
      end
    endcase
  end

  assign st_o = nx;

  assign res_o.scl_level  = nx.scl;
  assign res_o.sda_level  = nx.sda_drive ? nx.sda : 1'b1;
  assign res_o.sda_drive  = nx.sda_drive;
  assign res_o.busy_res   = (nx.phase != i2cm_pkg::PH_IDLE);
  assign res_o.done_res   = done;
  assign res_o.rx_byte    = nx.rx;
  assign res_o.ack_failed = nx.ack_fail;

endmodule

[src/i2c_master_byte_engine_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top
// I2C master line engine: one input word per bus tick, one result word back.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one tick of the bus timebase: an optional command
//   (start, stop, write byte, wait acknowledge, read byte) plus the sampled
//   SDA level. Commands are taken only while the engine is idle.
//   Each accepted word yields exactly one result word with the SCL level,
//   SDA level and drive enable, busy, a done pulse, the last received byte
//   and the acknowledge-fail flag, all as they stand after that tick.
//   An accepted word waits in the input register; its result then moves to
//   the result register and out_data. Throughput: one word per cycle when
//   not stalled; the next word is taken while the previous one is evaluated.
//   The cycle is set by the single pass of the phase sequencer between the
//   input register and the result register.
//   Config: cfg_we writes cfg_data into register cfg_index (0 ticks per
//   microsecond, 1 acknowledge timeout); write only while idle.
//   Reset: synchronous, active low; engine idle, SCL and SDA high and
//   driven, configuration back to 16 ticks per microsecond and 250 us.
//   Stall: a stalled result holds; the input register then holds its word
//   and raises in_stall. No word is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  logic                in_v_r;
  i2cm_pkg::in_word_t  in_d_r;
  logic                out_v_r;
  i2cm_pkg::out_word_t out_d_r;
  i2cm_pkg::state_t    st_r;
  i2cm_pkg::state_t    st_nxt;
  i2cm_pkg::out_word_t res_nxt;
  logic [7:0]          ticks_per_us_r;
  logic [7:0]          ack_timeout_r;
  logic                advance;
  logic                fire;

  // Result slot is free, or its word leaves this cycle
  assign advance  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !advance;
  assign fire     = in_v_r && advance;

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_us_r <= i2cm_pkg::TICKS_PER_US_RST;
      ack_timeout_r  <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == i2cm_pkg::CFG_TICKS_PER_US) begin
        ticks_per_us_r <= cfg_data;
      end else begin
        ack_timeout_r <= cfg_data;
      end
    end
  end

  // Input register: load when empty or when its word moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_d_r <= in_data;
    end
  end

  i2cm_step u_step (
    .st_i           (st_r),
    .word_i         (in_d_r),
    .ticks_per_us_i (ticks_per_us_r),
    .ack_timeout_i  (ack_timeout_r),
    .st_o           (st_nxt),
    .res_o          (res_nxt)
  );

  // Engine state: advance once per evaluated tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase             <= i2cm_pkg::PH_IDLE;
      st_r.pending_op        <= 3'd0;
      st_r.bit_count         <= 4'd0;
      st_r.prescale_count    <= 8'd0;
      st_r.microsecond_count <= 8'd0;
      st_r.shift_byte        <= 8'd0;
      st_r.ack_choice        <= 1'b0;
      st_r.scl               <= 1'b1;
      st_r.sda               <= 1'b1;
      st_r.sda_drive         <= 1'b1;
      st_r.rx                <= 8'd0;
      st_r.ack_fail          <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_d_r <= res_nxt;
    end
  end

endmodule

[sim/i2c_master_byte_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top_tb
// Self-checking bench for the I2C master line engine. A directed script walks
// every command, the acknowledge timeout, ignored and unknown commands, then
// random bus transactions run under several timing settings. Every word
// accepted on the input side is run through a cycle model of the engine and
// the resulting line word is checked against the next word the block returns.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top_tb;

  // Limit on cycles with no word moving on either side
  localparam int QUIET_LIMIT = 1000;

  // Line word right after reset: SCL and SDA high and driven, nothing running
  localparam i2cm_pkg::out_word_t LINE_RESET =
    {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

  // How the simulated slave drives SDA while a command runs
  typedef enum logic [1:0] {
    SDA_LOW,   // held low: immediate acknowledge, all-zero read
    SDA_HIGH,  // held high: no acknowledge, all-one read
    SDA_RAND,  // random every tick
    SDA_LATE   // high for a number of ticks, then low
  } sda_plan_t;

  typedef struct packed {
    i2cm_pkg::in_word_t  word;
    sda_plan_t           plan;
    logic                noisy;   // offer stray commands while the engine is busy
    logic                typed;   // first tick checked against line below
    i2cm_pkg::out_word_t line;
  } row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  i2cm_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  i2cm_pkg::out_word_t out_data;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = i2cm_pkg::CFG_TICKS_PER_US;
  logic [7:0]          cfg_data  = '0;

  // Engine model and its copy of the timing registers
  i2cm_pkg::state_t eng;
  logic [7:0]       tpu_now;
  logic [7:0]       ack_limit;

  i2cm_pkg::out_word_t pending_lines[$];
  bit         calm        = 1'b0;
  int         bad_count   = 0;
  int         lines_seen  = 0;
  int         quiet_cycles = 0;

  i2c_master_byte_engine_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Engine model: one call per accepted word, returns the line word after it
  // --------------------------------------------------------------------------
  function automatic void restart_timer();
    eng.prescale_count    = '0;
    eng.microsecond_count = '0;
  endfunction

  // Advance the prescaler; true once per elapsed microsecond
  function automatic bit us_elapsed();
    logic [7:0] lim;
    lim = (tpu_now == 8'd0) ? 8'd1 : tpu_now;
    eng.prescale_count = eng.prescale_count + 8'd1;
    if (eng.prescale_count >= lim) begin
      eng.prescale_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // True once n microseconds have passed in the current step
  function automatic bit span_over(input logic [7:0] n);
    if (us_elapsed()) begin
      eng.microsecond_count = eng.microsecond_count + 8'd1;
      if (eng.microsecond_count >= n) begin
        eng.microsecond_count = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void enter_stop();
    eng.sda_drive = 1'b1;
    eng.scl       = 1'b0;
    eng.sda       = 1'b0;
    restart_timer();
    eng.phase     = i2cm_pkg::PH_SP_A;
  endfunction

  function automatic void shift_out();
    eng.sda        = eng.shift_byte[7];
    eng.shift_byte = eng.shift_byte << 1;
  endfunction

  function automatic i2cm_pkg::out_word_t engine_tick(input i2cm_pkg::in_word_t w);
    i2cm_pkg::out_word_t r;
    logic                fin;
    fin = 1'b0;
    case (eng.phase)
      i2cm_pkg::PH_IDLE: begin
        if (w.command_valid && w.operation <= i2cm_pkg::OP_READ) begin
          eng.pending_op = w.operation;
          restart_timer();
          eng.bit_count = '0;
          case (w.operation)
            i2cm_pkg::OP_START: begin
              eng.sda_drive = 1'b1;
              eng.sda       = 1'b1;
              eng.scl       = 1'b1;
              eng.phase     = i2cm_pkg::PH_ST_A;
            end
            i2cm_pkg::OP_STOP: enter_stop();
            i2cm_pkg::OP_WRITE: begin
              eng.sda_drive  = 1'b1;
              eng.scl        = 1'b0;
              eng.shift_byte = w.tx_byte;
              shift_out();
              eng.phase      = i2cm_pkg::PH_W_LOW;
            end
            i2cm_pkg::OP_WAIT_ACK: begin
              eng.sda_drive = 1'b0;
              eng.sda       = 1'b1;
              eng.phase     = i2cm_pkg::PH_A_REL;
            end
            default: begin
              eng.sda_drive  = 1'b0;
              eng.sda        = 1'b1;
              eng.scl        = 1'b0;
              eng.shift_byte = '0;
              eng.ack_choice = w.send_ack;
              eng.phase      = i2cm_pkg::PH_R_LOW;
            end
          endcase
        end
      end
      i2cm_pkg::PH_ST_A: if (span_over(i2cm_pkg::START_STOP_US)) begin
        eng.sda   = 1'b0;
        eng.phase = i2cm_pkg::PH_ST_B;
      end
      i2cm_pkg::PH_ST_B: if (span_over(i2cm_pkg::START_STOP_US)) begin
        eng.scl   = 1'b0;
        eng.phase = i2cm_pkg::PH_IDLE;
        fin       = 1'b1;
      end
      i2cm_pkg::PH_SP_A: if (span_over(i2cm_pkg::START_STOP_US)) begin
        eng.scl   = 1'b1;
        eng.phase = i2cm_pkg::PH_SP_B;
      end
      i2cm_pkg::PH_SP_B: if (span_over(i2cm_pkg::STEP_US)) begin
        eng.sda   = 1'b1;
        eng.phase = i2cm_pkg::PH_SP_C;
      end
      i2cm_pkg::PH_SP_C: if (span_over(i2cm_pkg::START_STOP_US)) begin
        eng.phase = i2cm_pkg::PH_IDLE;
        fin       = 1'b1;
      end
      i2cm_pkg::PH_W_LOW: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.scl   = 1'b1;
        eng.phase = i2cm_pkg::PH_W_HIGH;
      end
      i2cm_pkg::PH_W_HIGH: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.scl   = 1'b0;
        eng.phase = i2cm_pkg::PH_W_TAIL;
      end
      i2cm_pkg::PH_W_TAIL: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.bit_count = eng.bit_count + 4'd1;
        if (eng.bit_count >= i2cm_pkg::BYTE_BITS) begin
          eng.phase = i2cm_pkg::PH_IDLE;
          fin       = 1'b1;
        end else begin
          shift_out();
          eng.phase = i2cm_pkg::PH_W_LOW;
        end
      end
      i2cm_pkg::PH_A_REL: if (span_over(i2cm_pkg::STEP_US)) begin
        eng.scl   = 1'b1;
        eng.phase = i2cm_pkg::PH_A_RISE;
      end
      i2cm_pkg::PH_A_RISE: if (span_over(i2cm_pkg::STEP_US)) begin
        eng.phase = i2cm_pkg::PH_A_POLL;
      end
      i2cm_pkg::PH_A_POLL: begin
        if (w.sda_in == 1'b0) begin
          eng.scl      = 1'b0;
          eng.ack_fail = 1'b0;
          restart_timer();
          eng.phase    = i2cm_pkg::PH_IDLE;
          fin          = 1'b1;
        end else if (us_elapsed()) begin
          if (eng.microsecond_count >= ack_limit) begin
            eng.ack_fail = 1'b1;
            enter_stop();
          end else begin
            eng.microsecond_count = eng.microsecond_count + 8'd1;
          end
        end
      end
      i2cm_pkg::PH_R_LOW: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.scl        = 1'b1;
        eng.shift_byte = {eng.shift_byte[6:0], w.sda_in};
        eng.phase      = i2cm_pkg::PH_R_HIGH;
      end
      i2cm_pkg::PH_R_HIGH: if (span_over(i2cm_pkg::STEP_US)) begin
        eng.scl       = 1'b0;
        eng.bit_count = eng.bit_count + 4'd1;
        if (eng.bit_count >= i2cm_pkg::BYTE_BITS) begin
          eng.rx        = eng.shift_byte;
          eng.sda_drive = 1'b1;
          eng.sda       = ~eng.ack_choice;
          eng.phase     = i2cm_pkg::PH_K_LOW;
        end else begin
          eng.phase = i2cm_pkg::PH_R_LOW;
        end
      end
      i2cm_pkg::PH_K_LOW: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.scl   = 1'b1;
        eng.phase = i2cm_pkg::PH_K_HIGH;
      end
      i2cm_pkg::PH_K_HIGH: if (span_over(i2cm_pkg::HALF_BIT_US)) begin
        eng.scl   = 1'b0;
        eng.phase = i2cm_pkg::PH_IDLE;
        fin       = 1'b1;
      end
      default: eng.phase = i2cm_pkg::PH_IDLE;
    endcase
    r.scl_level  = eng.scl;
    r.sda_level  = eng.sda_drive ? eng.sda : 1'b1;
    r.sda_drive  = eng.sda_drive;
    r.busy_res   = (eng.phase != i2cm_pkg::PH_IDLE);
    r.done_res   = fin;
    r.rx_byte    = eng.rx;
    r.ack_failed = eng.ack_fail;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, check each word against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic log_bad(input string why, input i2cm_pkg::out_word_t want,
                         input i2cm_pkg::out_word_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("word %0d %s: want scl=%b sda=%b drv=%b busy=%b done=%b rx=%h af=%b",
               lines_seen, why, want.scl_level, want.sda_level, want.sda_drive,
               want.busy_res, want.done_res, want.rx_byte, want.ack_failed);
      $display("          got  scl=%b sda=%b drv=%b busy=%b done=%b rx=%h af=%b",
               got.scl_level, got.sda_level, got.sda_drive, got.busy_res,
               got.done_res, got.rx_byte, got.ack_failed);
    end
  endtask

  int hold_left = 0;

  always @(posedge clk) begin : result_side
    int                  nxt;
    i2cm_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      nxt = hold_left;
      if (out_valid && !out_stall) begin
        if (pending_lines.size() == 0) begin
          log_bad("arrived with nothing expected", '0, out_data);
        end else begin
          want = pending_lines.pop_front();
          // compare each field on its own
          if (out_data.scl_level  !== want.scl_level  ||
              out_data.sda_level  !== want.sda_level  ||
              out_data.sda_drive  !== want.sda_drive  ||
              out_data.busy_res   !== want.busy_res   ||
              out_data.done_res   !== want.done_res   ||
              out_data.rx_byte    !== want.rx_byte    ||
              out_data.ack_failed !== want.ack_failed) begin
            log_bad("differs", want, out_data);
          end
        end
        lines_seen++;
        // draw the stall that follows this word
        nxt = calm ? 0 : int'($urandom_range(0, 16));
      end
      if (nxt > 0) begin
        out_stall <= 1'b1;
        hold_left <= nxt - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Drive one word after a random gap, hold it until taken, then predict.
  // Keep valid high across back-to-back words.
  task automatic send_word(input i2cm_pkg::in_word_t w, input bit typed,
                           input i2cm_pkg::out_word_t typed_line);
    int                  gap;
    i2cm_pkg::out_word_t line;
    gap = calm ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    line = engine_tick(w);
    pending_lines.push_back(typed ? typed_line : line);
  endtask

  // Drop valid and wait until every expected word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both timing registers on consecutive edges; only when drained
  task automatic program_timing(input logic [7:0] tpu, input logic [7:0] ack_us);
    cfg_we    <= 1'b1;
    cfg_index <= i2cm_pkg::CFG_TICKS_PER_US;
    cfg_data  <= tpu;
    @(posedge clk);
    cfg_index <= i2cm_pkg::CFG_ACK_TIMEOUT;
    cfg_data  <= ack_us;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tpu_now   = tpu;
    ack_limit = ack_us;
  endtask

  function automatic logic slave_sda(input sda_plan_t plan, input int n, input int hold);
    case (plan)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      SDA_LATE: return (n < hold) ? 1'b1 : 1'b0;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Offer one command, then feed bus ticks until the engine is idle again or
  // the budget runs out. Filler ticks may carry stray commands.
  task automatic run_cmd(input i2cm_pkg::in_word_t w, input sda_plan_t plan, input int hold,
                         input bit noisy, input bit typed,
                         input i2cm_pkg::out_word_t typed_line,
                         input int budget, output int used);
    i2cm_pkg::in_word_t f;
    w.sda_in = slave_sda(plan, 0, hold);
    send_word(w, typed, typed_line);
    used = 1;
    while (eng.phase != i2cm_pkg::PH_IDLE && used < budget) begin
      f.command_valid = noisy && ($urandom_range(0, 3) == 0);
      f.operation     = 3'($urandom_range(0, 7));
      f.tx_byte       = 8'($urandom_range(0, 255));
      f.send_ack      = 1'($urandom_range(0, 1));
      f.sda_in        = slave_sda(plan, used, hold);
      send_word(f, 1'b0, '0);
      used++;
    end
  endtask

  task automatic random_cmd(input logic [2:0] op, input int budget, output int used);
    i2cm_pkg::in_word_t w;
    sda_plan_t          plan;
    int                 hold;
    w.command_valid = 1'b1;
    w.operation     = op;
    w.tx_byte       = 8'($urandom_range(0, 255));
    w.send_ack      = 1'($urandom_range(0, 1));
    w.sda_in        = 1'b0;
    plan = SDA_RAND;
    hold = int'($urandom_range(0, 40));
    if (op == i2cm_pkg::OP_WAIT_ACK) begin
      plan = ($urandom_range(0, 3) == 0) ? SDA_HIGH : SDA_LATE;
    end
    run_cmd(w, plan, hold, 1'($urandom_range(0, 1)), 1'b0, '0, budget, used);
  endtask

  // One timing setting: drain, program, then transactions until the budget
  // is spent. The last command is often cut short, so the next register
  // write lands while the engine is mid-sequence.
  task automatic run_phase(input logic [7:0] tpu, input logic [7:0] ack_us,
                           input int budget, input bit calm_mode);
    int                 left;
    int                 used;
    int                 pick;
    int                 reps;
    logic [2:0]         seq[$];
    i2cm_pkg::in_word_t w;
    settle();
    program_timing(tpu, ack_us);
    calm = calm_mode;
    left = budget;
    while (left > 0) begin
      pick = int'($urandom_range(0, 9));
      seq.delete();
      if (pick == 0) begin
        // stray word at idle: no command or an unknown one
        w.command_valid = 1'($urandom_range(0, 1));
        w.operation     = w.command_valid ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 7));
        w.tx_byte       = 8'($urandom_range(0, 255));
        w.send_ack      = 1'($urandom_range(0, 1));
        w.sda_in        = 1'b0;
        run_cmd(w, SDA_RAND, 0, 1'b0, 1'b0, '0, 1, used);
        left -= used;
      end else begin
        if (pick == 1) begin
          // broken sequence: a lone command
          seq.push_back(3'($urandom_range(0, 4)));
        end else begin
          // start, address, acknowledge, a few data bytes, stop
          seq.push_back(i2cm_pkg::OP_START);
          seq.push_back(i2cm_pkg::OP_WRITE);
          seq.push_back(i2cm_pkg::OP_WAIT_ACK);
          reps = int'($urandom_range(1, 3));
          repeat (reps) begin
            if ($urandom_range(0, 1)) begin
              seq.push_back(i2cm_pkg::OP_WRITE);
              seq.push_back(i2cm_pkg::OP_WAIT_ACK);
            end else begin
              seq.push_back(i2cm_pkg::OP_READ);
            end
          end
          seq.push_back(i2cm_pkg::OP_STOP);
        end
        while (seq.size() != 0 && left > 0) begin
          random_cmd(seq.pop_front(), left, used);
          left -= used;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic row_t mk_row(input logic cv, input logic [2:0] op, input logic [7:0] tx,
                                  input logic ack, input sda_plan_t plan, input logic noisy,
                                  input logic typed, input i2cm_pkg::out_word_t line);
    row_t r;
    r.word  = {cv, op, tx, ack, 1'b0};
    r.plan  = plan;
    r.noisy = noisy;
    r.typed = typed;
    r.line  = line;
    return r;
  endfunction

  initial begin : stimulus
    row_t script[18];
    int   used;
    int   i;

    // model state after reset
    eng           = '0;
    eng.phase     = i2cm_pkg::PH_IDLE;
    eng.scl       = 1'b1;
    eng.sda       = 1'b1;
    eng.sda_drive = 1'b1;
    tpu_now       = i2cm_pkg::TICKS_PER_US_RST;
    ack_limit     = i2cm_pkg::ACK_TIMEOUT_RST;

    // Directed script. Typed lines give the first tick of a row where it is
    // plain to read; the remaining ticks of every row go through the model.
    // idle and unknown commands leave the reset lines alone
    script[0]  = mk_row(1'b0, i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b1,
                        LINE_RESET);
    script[1]  = mk_row(1'b1, 3'd5, 8'hFF, 1'b1, SDA_HIGH, 1'b0, 1'b1, LINE_RESET);
    script[2]  = mk_row(1'b1, 3'd6, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b1, LINE_RESET);
    script[3]  = mk_row(1'b1, 3'd7, 8'h5A, 1'b1, SDA_HIGH, 1'b0, 1'b1, LINE_RESET);
    // start: SCL and SDA held high first
    script[4]  = mk_row(1'b1, i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b1,
                        {1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    // write extremes, stray commands offered while busy on the first one
    script[5]  = mk_row(1'b1, i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b1, 1'b1,
                        {1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    script[6]  = mk_row(1'b1, i2cm_pkg::OP_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b0, 1'b1,
                        {1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    // acknowledge at once: SDA released
    script[7]  = mk_row(1'b1, i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_LOW, 1'b0, 1'b1,
                        {1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
    script[8]  = mk_row(1'b1, i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0, 1'b0, '0);
    // no acknowledge: timeout, stop follows and the fail flag sets
    script[9]  = mk_row(1'b1, i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_HIGH, 1'b0, 1'b1,
                        {1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
    script[10] = mk_row(1'b1, i2cm_pkg::OP_START, 8'h3C, 1'b1, SDA_RAND, 1'b1, 1'b1,
                        {1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1});
    // reads with ACK and NACK, random, all ones, all zeros
    script[11] = mk_row(1'b1, i2cm_pkg::OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b1, 1'b1,
                        {1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1});
    script[12] = mk_row(1'b1, i2cm_pkg::OP_READ, 8'hFF, 1'b0, SDA_HIGH, 1'b0, 1'b0, '0);
    script[13] = mk_row(1'b1, i2cm_pkg::OP_READ, 8'h00, 1'b1, SDA_LOW, 1'b0, 1'b0, '0);
    // late acknowledge clears the fail flag
    script[14] = mk_row(1'b1, i2cm_pkg::OP_WAIT_ACK, 8'h00, 1'b0, SDA_LATE, 1'b1, 1'b0, '0);
    script[15] = mk_row(1'b1, i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 1'b0, '0);
    script[16] = mk_row(1'b0, i2cm_pkg::OP_READ, 8'hFF, 1'b1, SDA_RAND, 1'b0, 1'b0, '0);
    // a second stop, one idle word after the first
    script[17] = mk_row(1'b1, i2cm_pkg::OP_STOP, 8'h80, 1'b1, SDA_RAND, 1'b1, 1'b0, '0);

    // hold reset, then release it once
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short timing so every directed command runs to its end
    program_timing(8'd1, 8'd2);
    calm = 1'b0;
    for (i = 0; i < 18; i++) begin
      run_cmd(script[i].word, script[i].plan, 5, script[i].noisy, script[i].typed,
              script[i].line, 100000, used);
    end

    // random transactions under several settings, extremes among them;
    // each phase drains fully before its register writes
    run_phase(8'd1, 8'd3, 60, 1'b0);
    run_phase(8'd0, 8'd0, 50, 1'b0);
    run_phase(8'd2, 8'd1, 60, 1'b1);
    run_phase(8'd255, 8'd255, 200, 1'b1);
    run_phase(8'd1, 8'd255, 80, 1'b0);
    run_phase(8'd16, 8'd250, 50, 1'b1);
    run_phase(8'd3, 8'($urandom_range(2, 30)), 50, 1'b0);
    run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(0, 12)), 50, 1'b0);

    // wait for the last words, then give anything stray time to show
    settle();
    repeat (8) @(posedge clk);
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
